// ===== rtl/core/text_cell_console_writer_top_macros.svh =====
`ifndef TEXT_CELL_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CELL_CONSOLE_WRITER_TOP_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

	localparam int CELL_W = 16;

	localparam logic       ACT_PUT  = 1'b0;
	localparam logic       ACT_READ = 1'b1;

	localparam logic [7:0] CHAR_BS    = 8'd8;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [7:0]        ATTR_RESET = 8'h07;
	localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

	typedef struct packed {
		logic        action;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_location;
		logic [15:0] read_data;
		logic        scrolled;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUT,
		ST_TAB,
		ST_SCROLL_COPY,
		ST_SCROLL_FILL,
		ST_DONE
	} tcw_state_t;

endpackage

// ===== rtl/core/tcw_grid_ram.sv =====
module tcw_grid_ram import tcw_pkg::*; #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/text_cell_console_writer_top.sv =====
// Text console engine: a COLUMNS x ROWS grid of 16-bit cells (attribute high byte, character
// low byte) held in one grid RAM with a registered read port, plus a cursor. After reset the
// block sweeps all ROWS*COLUMNS cells (2000 by default) to blank and holds cmd_ready low
// until done; cfg writes are taken at any time. One item is worked at a time: a read sends
// its RAM read on accept and is loaded into the result in ST_DONE; a put, newline, return or
// backspace passes ST_PUT, a tab then ST_TAB, which writes blanks up to the next tab stop or
// the row end (at most TAB_WIDTH). A put past the last row scrolls: the grid RAM moves one
// cell per cycle a row up, then blanks the bottom row. Results leave via an output register.
module text_cell_console_writer_top import tcw_pkg::*; #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int LW = $clog2(CELL_COUNT + 1);
	localparam int CW = $clog2(COLUMNS + 1);
	localparam int RW = $clog2(ROWS + 1);
	localparam int PW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
	localparam int IW = (AW >= 11) ? AW + 1 : 12;

	localparam logic [CW-1:0] COL_END   = CW'(COLUMNS);
	localparam logic [RW-1:0] ROW_END   = RW'(ROWS);
	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [PW-1:0] PH_LAST   = PW'(TAB_WIDTH - 1);
	localparam logic [LW-1:0] LIN_COLS  = LW'(COLUMNS);
	localparam logic [AW-1:0] CELL_LAST = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] COPY_BASE = AW'(COLUMNS);
	localparam logic [AW-1:0] FILL_BASE = AW'((ROWS - 1) * COLUMNS);
	localparam logic [IW-1:0] IDX_LIMIT = IW'(CELL_COUNT);

	tcw_state_t state_q, state_d;

	logic [CW-1:0] col_q, col_d, nc;
	logic [RW-1:0] row_q, row_d, nr;
	logic [LW-1:0] lin_q, lin_d, nl;
	logic [PW-1:0] ph_q, ph_d, np;
	logic          settle;

	logic [7:0]    attr_q;
	logic [7:0]    char_q, char_d;
	logic          is_read_q, is_read_d;
	logic          in_range_q, in_range_d;
	logic          scrolled_q, scrolled_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic          copy_vld_s1, copy_vld_d;
	logic [AW-1:0] copy_dst_s1, copy_dst_d;
	logic          res_valid_q;
	res_t          res_q;
	logic          res_load;

	logic [IW-1:0]     idx_ext;
	logic              idx_ok;
	logic [CELL_W-1:0] blank;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	assign blank   = {attr_q, CHAR_SPACE};
	assign idx_ext = IW'(cmd.cell_index);
	assign idx_ok  = idx_ext < IDX_LIMIT;

	tcw_grid_ram #(
		.DEPTH (CELL_COUNT),
		.AW    (AW)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d    = state_q;
		nc         = col_q;
		nr         = row_q;
		nl         = lin_q;
		np         = ph_q;
		settle     = 1'b0;
		char_d     = char_q;
		is_read_d  = is_read_q;
		in_range_d = in_range_q;
		scrolled_d = scrolled_q;
		ptr_d      = ptr_q;
		copy_vld_d = 1'b0;
		copy_dst_d = copy_dst_s1;
		cmd_ready  = 1'b0;
		res_load   = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = ptr_q;
		mem_we     = 1'b0;
		mem_waddr  = lin_q[AW-1:0];
		mem_wdata  = blank;

		// finish the row move issued last cycle
		if (copy_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = copy_dst_s1;
			mem_wdata = mem_rdata;
		end

		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = CELL_RESET;
				if (ptr_q == CELL_LAST) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					char_d     = cmd.char_code;
					is_read_d  = (cmd.action == ACT_READ);
					in_range_d = idx_ok;
					scrolled_d = 1'b0;
					if (cmd.action == ACT_READ) begin
						mem_re    = 1'b1;
						mem_raddr = idx_ok ? idx_ext[AW-1:0] : '0;
						state_d   = ST_DONE;
					end else begin
						state_d = ST_PUT;
					end
				end
			end
			ST_PUT: begin
				case (char_q)
					CHAR_LF: begin
						nc     = '0;
						np     = '0;
						nr     = row_q + 1'b1;
						nl     = lin_q - LW'(col_q) + LIN_COLS;
						settle = 1'b1;
					end
					CHAR_CR: begin
						nc     = '0;
						np     = '0;
						nl     = lin_q - LW'(col_q);
						settle = 1'b1;
					end
					CHAR_TAB: begin
						state_d = ST_TAB;
					end
					CHAR_BS: begin
						if (col_q != '0) begin
							nc        = col_q - 1'b1;
							np        = (ph_q == '0) ? PH_LAST : ph_q - 1'b1;
							nl        = lin_q - 1'b1;
							mem_we    = 1'b1;
							mem_waddr = nl[AW-1:0];
							mem_wdata = blank;
						end
						settle = 1'b1;
					end
					default: begin
						mem_we    = 1'b1;
						mem_waddr = lin_q[AW-1:0];
						mem_wdata = {attr_q, char_q};
						nc        = col_q + 1'b1;
						np        = (ph_q == PH_LAST) ? '0 : ph_q + 1'b1;
						nl        = lin_q + 1'b1;
						settle    = 1'b1;
					end
				endcase
			end
			ST_TAB: begin
				mem_we    = 1'b1;
				mem_waddr = lin_q[AW-1:0];
				mem_wdata = blank;
				nc        = col_q + 1'b1;
				np        = (ph_q == PH_LAST) ? '0 : ph_q + 1'b1;
				nl        = lin_q + 1'b1;
				// keep blanking until a tab stop or the row end
				if (np == '0 || nc == COL_END) begin
					settle = 1'b1;
				end
			end
			ST_SCROLL_COPY: begin
				mem_re     = 1'b1;
				mem_raddr  = ptr_q;
				copy_vld_d = 1'b1;
				copy_dst_d = ptr_q - COPY_BASE;
				if (ptr_q == CELL_LAST) begin
					ptr_d   = FILL_BASE;
					state_d = ST_SCROLL_FILL;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_SCROLL_FILL: begin
				// the last moved cell takes the write port first
				if (!copy_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ptr_q;
					mem_wdata = blank;
					if (ptr_q == CELL_LAST) begin
						ptr_d   = '0;
						state_d = ST_DONE;
					end else begin
						ptr_d = ptr_q + 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// wrap at the row end, scroll past the last row
		if (settle) begin
			if (nc == COL_END) begin
				nc = '0;
				np = '0;
				nr = nr + 1'b1;
			end
			if (nr == ROW_END) begin
				nr         = ROW_LAST;
				nl         = nl - LIN_COLS;
				scrolled_d = 1'b1;
				ptr_d      = COPY_BASE;
				state_d    = ST_SCROLL_COPY;
			end else begin
				state_d = ST_DONE;
			end
		end

		col_d = nc;
		row_d = nr;
		lin_d = nl;
		ph_d  = np;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			col_q       <= '0;
			row_q       <= '0;
			lin_q       <= '0;
			ph_q        <= '0;
			ptr_q       <= '0;
			copy_vld_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			attr_q      <= ATTR_RESET;
		end else begin
			state_q     <= state_d;
			col_q       <= col_d;
			row_q       <= row_d;
			lin_q       <= lin_d;
			ph_q        <= ph_d;
			ptr_q       <= ptr_d;
			copy_vld_s1 <= copy_vld_d;
			if (cfg_we) begin
				attr_q <= cfg_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		char_q      <= char_d;
		is_read_q   <= is_read_d;
		in_range_q  <= in_range_d;
		scrolled_q  <= scrolled_d;
		copy_dst_s1 <= copy_dst_d;
		if (res_load) begin
			res_q.cursor_col      <= 7'(col_q);
			res_q.cursor_row      <= 5'(row_q);
			res_q.cursor_location <= 11'(lin_q);
			res_q.read_data       <= (is_read_q && in_range_q) ? mem_rdata : '0;
			res_q.scrolled        <= scrolled_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/core/tcw_checker.sv =====
`include "text_cell_console_writer_top_macros.svh"

module tcw_checker import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// cursor fields are exact only while they fit the result widths
	localparam bit EXACT = (COLUMNS <= 128) && (ROWS <= 32) && (COLUMNS * ROWS <= 2048);

	logic [10:0] loc_calc;
	logic        res_stall;
	logic        loc_ok;
	logic        scroll_ok;

	assign loc_calc  = 11'(32'(res.cursor_row) * COLUMNS + 32'(res.cursor_col));
	assign res_stall = res_valid && !res_ready;
	assign loc_ok    = (32'(res.cursor_col) < COLUMNS) && (32'(res.cursor_row) < ROWS) &&
		(res.cursor_location == loc_calc);
	assign scroll_ok = (res.read_data == 16'h0000) && (res.cursor_row == 5'(ROWS - 1));

	`TCW_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res), "result changed in a stall")

	`TCW_ASSERT_SAME(a_cursor_loc, res_valid && EXACT, loc_ok, "cursor location off its row and column")

	`TCW_ASSERT_SAME(a_scroll_row, res_valid && res.scrolled, scroll_ok, "scroll result not on last row")

	`TCW_ASSERT_SAME(a_clear_busy, $rose(arst_n), !cmd_ready, "item taken before the grid was cleared")

endmodule

bind text_cell_console_writer_top tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_ready (cmd_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
